// ----- rtl/shell_command_tokenizer_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Shell command tokenizer assertion macros
// Shared property forms for the tokenizer blocks; clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef SHELL_COMMAND_TOKENIZER_UNIT_ASSERT_SVH
`define SHELL_COMMAND_TOKENIZER_UNIT_ASSERT_SVH

// same-cycle implication
`define SCT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SCT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/sct_pkg.sv -----
// ----------------------------------------------------------------------------
// Shell command tokenizer package
// Token kinds, byte codes and the token group type passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package sct_pkg;

	localparam logic [3:0] KIND_WORD     = 4'd0;
	localparam logic [3:0] KIND_PIPE     = 4'd1;
	localparam logic [3:0] KIND_OR       = 4'd2;
	localparam logic [3:0] KIND_AND      = 4'd3;
	localparam logic [3:0] KIND_INPUT    = 4'd4;
	localparam logic [3:0] KIND_OUTPUT   = 4'd5;
	localparam logic [3:0] KIND_APPEND   = 4'd6;
	localparam logic [3:0] KIND_HEREDOC  = 4'd7;
	localparam logic [3:0] KIND_LPAREN   = 4'd8;
	localparam logic [3:0] KIND_RPAREN   = 4'd9;
	localparam logic [3:0] KIND_END      = 4'd10;
	localparam logic [3:0] KIND_UNCLOSED = 4'd11;
	localparam logic [3:0] KIND_NONE     = 4'd15;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_PIPE    = 8'h7C;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_GT      = 8'h3E;
	localparam logic [7:0] CH_LT      = 8'h3C;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_SQUOTE  = 8'h27;

	// queue between front and back, in token groups
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [3:0]  kind;
		logic [11:0] start_pos;
		logic [11:0] end_pos;
		logic        last;
	} sct_token_t;

	// all tokens caused by one input word
	typedef struct packed {
		logic [1:0]           count;
		sct_token_t [2:0]     tok;
	} sct_group_t;

endpackage

`default_nettype wire

// ----- rtl/shell_command_tokenizer_unit.sv -----
// ----------------------------------------------------------------------------
// Shell command tokenizer
// Splits a command line, one byte per word, into shell words and operators.
// ----------------------------------------------------------------------------
// Bytes of a line come in on the input channel, the last one flagged by
// end_of_line; tokens leave on the output channel with their kind, inclusive
// start and end positions, and last_of_line set on the end marker or the
// unclosed-quote error that closes each line. The input takes one byte per
// cycle whenever the four-group queue between the lexer front end and the
// token back end has room; a byte yields zero to three tokens, and the back
// end delivers one token per cycle while out_ready is high, so sustained
// input rate is one byte per cycle as long as bytes average at most one
// token each and the output is not stalled. As the lexer holds one byte of
// lookahead, a token is reported when the byte after it is taken or at line
// end; it then passes the group queue and the group register of the back end
// on its way out. Positions saturate at MAX_LINE-1, reported in twelve bits.
// ----------------------------------------------------------------------------
`default_nettype none

module shell_command_tokenizer_unit import sct_pkg::*; #(
	parameter int unsigned MAX_LINE = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_byte,
	input  wire logic        end_of_line,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       token_kind,
	output logic [11:0]      start_pos,
	output logic [11:0]      end_pos,
	output logic             last_of_line
);

	logic       push_valid;
	sct_group_t push_group;
	logic       queue_full;
	logic       queue_empty;
	logic       pop;
	sct_group_t pop_group;

	sct_front #(
		.MAX_LINE(MAX_LINE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_byte  (char_byte),
		.end_of_line(end_of_line),
		.push_valid (push_valid),
		.push_group (push_group),
		.queue_full (queue_full)
	);

	sct_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_group(push_group),
		.full      (queue_full),
		.pop       (pop),
		.pop_group (pop_group),
		.empty     (queue_empty)
	);

	sct_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.queue_group (pop_group),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.token_kind  (token_kind),
		.start_pos   (start_pos),
		.end_pos     (end_pos),
		.last_of_line(last_of_line)
	);

endmodule

`default_nettype wire

// ----- rtl/sct_front.sv -----
// ----------------------------------------------------------------------------
// Shell command tokenizer front end
// Holds the lexer state and one byte of lookahead; turns each accepted byte
// into a group of zero to three tokens and pushes nonempty groups.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_front import sct_pkg::*; #(
	parameter int unsigned MAX_LINE = 4096
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] char_byte,
	input  wire logic       end_of_line,
	output logic            push_valid,
	output sct_group_t      push_group,
	input  wire logic       queue_full
);

	localparam int unsigned PW = $clog2(MAX_LINE);
	localparam logic [PW:0]   LINE_LIM = (PW + 1)'(MAX_LINE);
	localparam logic [PW-1:0] POS_MAX  = PW'(MAX_LINE - 1);

	typedef struct packed {
		logic          in_word;
		logic [PW-1:0] wstart;
		logic          sq;
		logic          dq;
	} lex_t;

	typedef struct packed {
		lex_t       lex;
		sct_group_t grp;
		logic       consumed;
	} step_t;

	function automatic logic is_blank(logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL);
	endfunction

	function automatic logic [3:0] one_op(logic [7:0] b);
		logic [3:0] k;
		case (b)
			CH_PIPE:   k = KIND_PIPE;
			CH_LT:     k = KIND_INPUT;
			CH_GT:     k = KIND_OUTPUT;
			CH_LPAREN: k = KIND_LPAREN;
			CH_RPAREN: k = KIND_RPAREN;
			default:   k = KIND_NONE;
		endcase
		return k;
	endfunction

	function automatic logic [3:0] two_op(logic [7:0] a, logic [7:0] b);
		logic [3:0] k;
		k = KIND_NONE;
		if (a == b) begin
			case (a)
				CH_PIPE: k = KIND_OR;
				CH_AMP:  k = KIND_AND;
				CH_GT:   k = KIND_APPEND;
				CH_LT:   k = KIND_HEREDOC;
				default: k = KIND_NONE;
			endcase
		end
		return k;
	endfunction

	function automatic sct_group_t emit(sct_group_t g, logic [3:0] k, logic [PW-1:0] s,
			logic [PW-1:0] e, logic last);
		sct_group_t r;
		r = g;
		if (g.count != 2'd3) begin
			r.tok[g.count].kind      = k;
			r.tok[g.count].start_pos = 12'(s);
			r.tok[g.count].end_pos   = 12'(e);
			r.tok[g.count].last      = last;
			r.count                  = g.count + 2'd1;
		end
		return r;
	endfunction

	// one lexer step on byte h at position q, with optional lookahead n
	function automatic step_t handle(step_t st, logic [7:0] h, logic [PW-1:0] q,
			logic has_n, logic [7:0] n, logic [PW-1:0] npos);
		step_t         r;
		logic          done;
		logic [PW-1:0] wend;
		r          = st;
		r.consumed = 1'b0;
		done       = 1'b0;
		if (!r.lex.in_word) begin
			if (is_blank(h)) begin
				done = 1'b1;
			end else if (has_n && two_op(h, n) != KIND_NONE) begin
				r.grp      = emit(r.grp, two_op(h, n), q, npos, 1'b0);
				r.consumed = 1'b1;
				done       = 1'b1;
			end else if (one_op(h) != KIND_NONE) begin
				r.grp = emit(r.grp, one_op(h), q, q, 1'b0);
				done  = 1'b1;
			end else begin
				r.lex.in_word = 1'b1;
				r.lex.wstart  = q;
			end
		end
		wend = (q > r.lex.wstart) ? q - PW'(1) : r.lex.wstart;
		if (!done) begin
			if (h == CH_DQUOTE && !r.lex.sq) r.lex.dq = !r.lex.dq;
			if (h == CH_SQUOTE && !r.lex.dq) r.lex.sq = !r.lex.sq;
			if (!(r.lex.sq || r.lex.dq)) begin
				if (is_blank(h)) begin
					r.grp         = emit(r.grp, KIND_WORD, r.lex.wstart, wend, 1'b0);
					r.lex.in_word = 1'b0;
				end else if (h == CH_AMP && has_n && n == CH_AMP) begin
					r.grp         = emit(r.grp, KIND_WORD, r.lex.wstart, wend, 1'b0);
					r.grp         = emit(r.grp, KIND_AND, q, npos, 1'b0);
					r.lex.in_word = 1'b0;
					r.consumed    = 1'b1;
				end else if (has_n && one_op(n) != KIND_NONE) begin
					r.grp         = emit(r.grp, KIND_WORD, r.lex.wstart, q, 1'b0);
					r.lex.in_word = 1'b0;
				end
			end
		end
		return r;
	endfunction

	logic          held_valid_q;
	logic [7:0]    held_byte_q;
	logic [PW-1:0] held_pos_q;
	logic [PW-1:0] pos_q;
	lex_t          lex_q;

	step_t         st;
	logic          consumed;
	logic          hv;
	logic [7:0]    hb;
	logic [PW-1:0] hp;
	logic [PW:0]   pos_inc;
	logic [PW-1:0] pos_next;
	logic          accept;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign pos_inc  = {1'b0, pos_q} + (PW + 1)'(1);
	assign pos_next = (pos_inc < LINE_LIM) ? pos_inc[PW-1:0] : POS_MAX;

	always_comb begin
		st          = '0;
		st.lex      = lex_q;
		hv          = 1'b0;
		hb          = held_byte_q;
		hp          = held_pos_q;
		if (held_valid_q) begin
			st = handle(st, held_byte_q, held_pos_q, 1'b1, char_byte, pos_q);
		end
		consumed = st.consumed;
		if (!consumed) begin
			hb = char_byte;
			hp = pos_q;
			hv = 1'b1;
		end
		if (end_of_line) begin
			if (hv) begin
				st = handle(st, hb, hp, 1'b0, 8'h00, '0);
			end
			if (st.lex.in_word && (st.lex.sq || st.lex.dq)) begin
				st.grp = emit(st.grp, KIND_UNCLOSED, st.lex.wstart, pos_q, 1'b1);
			end else begin
				if (st.lex.in_word) begin
					st.grp = emit(st.grp, KIND_WORD, st.lex.wstart, pos_q, 1'b0);
				end
				st.grp = emit(st.grp, KIND_END, pos_q, pos_q, 1'b1);
			end
		end
	end

	assign push_valid = accept && (st.grp.count != 2'd0);
	assign push_group = st.grp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_byte_q  <= '0;
			held_pos_q   <= '0;
			pos_q        <= '0;
			lex_q        <= '0;
		end else if (accept) begin
			if (end_of_line) begin
				// close the line: back to the reset state
				held_valid_q <= 1'b0;
				held_byte_q  <= '0;
				held_pos_q   <= '0;
				pos_q        <= '0;
				lex_q        <= '0;
			end else begin
				held_valid_q <= hv;
				held_byte_q  <= hb;
				held_pos_q   <= hp;
				pos_q        <= pos_next;
				lex_q        <= st.lex;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sct_queue.sv -----
// ----------------------------------------------------------------------------
// Shell command tokenizer group queue
// Small FIFO of token groups that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_queue import sct_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push_valid,
	input  wire sct_group_t  push_group,
	output logic             full,
	input  wire logic        pop,
	output sct_group_t       pop_group,
	output logic             empty
);

	`include "shell_command_tokenizer_unit_assert.svh"

	sct_group_t         mem_q [QDEPTH];
	logic [QAW-1:0]     wr_ptr_q;
	logic [QAW-1:0]     rd_ptr_q;
	logic [QAW:0]       count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = count_q == (QAW + 1)'(QDEPTH);
	assign empty     = count_q == '0;
	assign do_push   = push_valid && !full;
	assign do_pop    = pop && !empty;
	assign pop_group = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_group;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + QAW'(1);
			if (do_push && !do_pop) begin
				count_q <= count_q + (QAW + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QAW + 1)'(1);
			end
		end
	end

	`SCT_ASSERT_NOW(a_no_push_when_full, push_valid, !full, "group pushed into full queue")
	`SCT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= (QAW + 1)'(QDEPTH), "queue count overflow")

endmodule

`default_nettype wire

// ----- rtl/sct_back.sv -----
// ----------------------------------------------------------------------------
// Shell command tokenizer back end
// Takes token groups from the queue and presents their tokens one at a time
// from a held group register.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_back import sct_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        queue_empty,
	input  wire sct_group_t  queue_group,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       token_kind,
	output logic [11:0]      start_pos,
	output logic [11:0]      end_pos,
	output logic             last_of_line
);

	`include "shell_command_tokenizer_unit_assert.svh"

	sct_group_t grp_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       last_idx;
	sct_token_t cur;

	assign last_idx = idx_q == (grp_q.count - 2'd1);
	// load the next group when idle, or as the last token of this one leaves
	assign pop      = !queue_empty && (!busy_q || (out_ready && last_idx));
	assign cur      = grp_q.tok[idx_q];

	assign out_valid    = busy_q;
	assign token_kind   = cur.kind;
	assign start_pos    = cur.start_pos;
	assign end_pos      = cur.end_pos;
	assign last_of_line = cur.last;

	always_ff @(posedge clk) begin
		if (pop) begin
			grp_q <= queue_group;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			busy_q <= 1'b0;
		end else if (pop) begin
			idx_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q && out_ready) begin
			if (last_idx) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	`SCT_ASSERT_NOW(a_idx_in_group, busy_q, (grp_q.count != 2'd0) && (idx_q < grp_q.count), "token index outside group")
	`SCT_ASSERT_NOW(a_no_empty_group, pop, queue_group.count != 2'd0, "empty group in queue")
	`SCT_ASSERT_NEXT(a_idx_advance, busy_q && out_ready && !last_idx && !pop, busy_q && (idx_q == $past(idx_q) + 2'd1), "token index did not advance")

endmodule

`default_nettype wire

// ----- tb/sv/token_stream_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Token stream checker
// Watches both channels of the shell command tokenizer, predicts the tokens of
// every accepted byte and compares each delivered token with the oldest one.
// ----------------------------------------------------------------------------

module token_stream_checker import sct_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [7:0]  char_byte,
	input  wire logic        end_of_line,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [3:0]  token_kind,
	input  wire logic [11:0] start_pos,
	input  wire logic [11:0] end_pos,
	input  wire logic        last_of_line,
	output int unsigned      mismatches,
	output int unsigned      tokens_pending,
	output int unsigned      tokens_checked
);

	localparam int unsigned LINE_LIMIT = 4096;

	sct_token_t expected_tokens[$];

	// lexer state
	logic [7:0]  look_byte;
	logic [11:0] look_pos;
	bit          look_valid;
	bit          in_word;
	logic [11:0] word_begin;
	int unsigned next_pos;
	bit          squote_open;
	bit          dquote_open;
	int unsigned step_tokens;

	int unsigned error_total;
	int unsigned checked_total;

	function automatic bit is_blank(input logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_NL;
	endfunction

	function automatic logic [3:0] single_op_kind(input logic [7:0] b);
		case (b)
			CH_PIPE:   return KIND_PIPE;
			CH_LT:     return KIND_INPUT;
			CH_GT:     return KIND_OUTPUT;
			CH_LPAREN: return KIND_LPAREN;
			CH_RPAREN: return KIND_RPAREN;
			default:   return KIND_NONE;
		endcase
	endfunction

	function automatic logic [3:0] pair_op_kind(input logic [7:0] a, input logic [7:0] b);
		if (a != b)
			return KIND_NONE;
		case (a)
			CH_PIPE: return KIND_OR;
			CH_AMP:  return KIND_AND;
			CH_GT:   return KIND_APPEND;
			CH_LT:   return KIND_HEREDOC;
			default: return KIND_NONE;
		endcase
	endfunction

	task automatic clear_line();
		look_byte   = 8'h00;
		look_pos    = 12'h000;
		look_valid  = 0;
		in_word     = 0;
		word_begin  = 12'h000;
		next_pos    = 0;
		squote_open = 0;
		dquote_open = 0;
	endtask

	task automatic add_token(input logic [3:0] kind, input logic [11:0] s, input logic [11:0] e,
			input logic last);
		sct_token_t t;
		if (step_tokens < 3) begin
			t.kind      = kind;
			t.start_pos = s;
			t.end_pos   = e;
			t.last      = last;
			expected_tokens.push_back(t);
			step_tokens++;
		end
	endtask

	// lex byte h at position q, with optional lookahead n at npos
	task automatic scan_byte(input logic [7:0] h, input logic [11:0] q, input bit has_next,
			input logic [7:0] n, input logic [11:0] npos, output bit took_next);
		logic [3:0]  k;
		logic [11:0] stop;
		took_next = 0;
		if (!in_word) begin
			if (is_blank(h))
				return;
			if (has_next) begin
				k = pair_op_kind(h, n);
				if (k != KIND_NONE) begin
					add_token(k, q, npos, 1'b0);
					took_next = 1;
					return;
				end
			end
			k = single_op_kind(h);
			if (k != KIND_NONE) begin
				add_token(k, q, q, 1'b0);
				return;
			end
			in_word    = 1;
			word_begin = q;
		end
		if (h == CH_DQUOTE && !squote_open)
			dquote_open = !dquote_open;
		if (h == CH_SQUOTE && !dquote_open)
			squote_open = !squote_open;
		if (squote_open || dquote_open)
			return;
		// word ends before this byte; clamp when positions have saturated
		stop = (q > word_begin) ? q - 12'd1 : word_begin;
		if (is_blank(h)) begin
			add_token(KIND_WORD, word_begin, stop, 1'b0);
			in_word = 0;
			return;
		end
		if (h == CH_AMP && has_next && n == CH_AMP) begin
			add_token(KIND_WORD, word_begin, stop, 1'b0);
			add_token(KIND_AND, q, npos, 1'b0);
			in_word   = 0;
			took_next = 1;
			return;
		end
		if (has_next && single_op_kind(n) != KIND_NONE) begin
			add_token(KIND_WORD, word_begin, q, 1'b0);
			in_word = 0;
		end
	endtask

	task automatic predict_byte(input logic [7:0] c, input bit eol);
		logic [11:0] p;
		bit          took;
		p           = next_pos[11:0];
		took        = 0;
		step_tokens = 0;
		next_pos    = (next_pos + 1 < LINE_LIMIT) ? next_pos + 1 : LINE_LIMIT - 1;
		if (look_valid) begin
			scan_byte(look_byte, look_pos, 1, c, p, took);
			look_valid = 0;
		end
		if (!took) begin
			look_byte  = c;
			look_pos   = p;
			look_valid = 1;
		end
		if (eol) begin
			if (look_valid) begin
				scan_byte(look_byte, look_pos, 0, 8'h00, 12'h000, took);
				look_valid = 0;
			end
			if (in_word && (squote_open || dquote_open)) begin
				add_token(KIND_UNCLOSED, word_begin, p, 1'b1);
			end else begin
				if (in_word)
					add_token(KIND_WORD, word_begin, p, 1'b0);
				add_token(KIND_END, p, p, 1'b1);
			end
			clear_line();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sct_token_t want;
		if (!arst_n) begin
			clear_line();
			expected_tokens.delete();
			error_total    = 0;
			checked_total  = 0;
			mismatches     <= 0;
			tokens_pending <= 0;
			tokens_checked <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_tokens.size() == 0) begin
					$error("unexpected token: kind %0d start %0d end %0d last %0d",
						token_kind, start_pos, end_pos, last_of_line);
					error_total++;
				end else begin
					want = expected_tokens.pop_front();
					checked_total++;
					if (token_kind !== want.kind) begin
						$error("token_kind: expected %0d, actual %0d", want.kind, token_kind);
						error_total++;
					end
					if (start_pos !== want.start_pos) begin
						$error("start_pos: expected %0d, actual %0d", want.start_pos, start_pos);
						error_total++;
					end
					if (end_pos !== want.end_pos) begin
						$error("end_pos: expected %0d, actual %0d", want.end_pos, end_pos);
						error_total++;
					end
					if (last_of_line !== want.last) begin
						$error("last_of_line: expected %0d, actual %0d", want.last, last_of_line);
						error_total++;
					end
				end
			end
			if (in_valid && in_ready)
				predict_byte(char_byte, end_of_line);
			mismatches     <= error_total;
			tokens_pending <= expected_tokens.size();
			tokens_checked <= checked_total;
		end
	end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shell command tokenizer testbench
// Feeds directed and random command lines with random idling on both sides;
// the checker module scores tokens.
// ----------------------------------------------------------------------------

module testbench;
	import sct_pkg::*;

	localparam int unsigned RANDOM_BYTES = 470;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  char_byte;
	logic        end_of_line;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  token_kind;
	logic [11:0] start_pos;
	logic [11:0] end_pos;
	logic        last_of_line;

	int unsigned mismatches;
	int unsigned tokens_pending;
	int unsigned tokens_checked;

	bit          calm;
	int unsigned bytes_sent;
	int unsigned lines_sent;

	shell_command_tokenizer_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_byte    (char_byte),
		.end_of_line  (end_of_line),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.token_kind   (token_kind),
		.start_pos    (start_pos),
		.end_pos      (end_pos),
		.last_of_line (last_of_line)
	);

	token_stream_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.char_byte      (char_byte),
		.end_of_line    (end_of_line),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.token_kind     (token_kind),
		.start_pos      (start_pos),
		.end_pos        (end_pos),
		.last_of_line   (last_of_line),
		.mismatches     (mismatches),
		.tokens_pending (tokens_pending),
		.tokens_checked (tokens_checked)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 36);
	end

	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic [7:0] blank_char();
		case ($urandom_range(2))
			0:       return CH_SPACE;
			1:       return CH_TAB;
			default: return CH_NL;
		endcase
	endfunction

	function automatic logic [7:0] op_char();
		string ops;
		ops = "|&<>()";
		return ops[$urandom_range(5)];
	endfunction

	function automatic logic [7:0] shell_char();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 30)
			return 8'($urandom_range(255));
		else if (r < 55)
			return op_char();
		else if (r < 73)
			return blank_char();
		else if (r < 80)
			return ($urandom_range(1) == 0) ? CH_SQUOTE : CH_DQUOTE;
		else
			return 8'(8'h61 + $urandom_range(25));
	endfunction

	task automatic send_byte(input logic [7:0] c, input bit eol);
		if (!calm && $urandom_range(99) < 36) begin
			in_valid    <= 1'b0;
			char_byte   <= 8'($urandom_range(255));
			end_of_line <= 1'($urandom_range(1));
			do @(posedge clk); while ($urandom_range(99) < 36);
		end
		in_valid    <= 1'b1;
		char_byte   <= c;
		end_of_line <= eol;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		if (eol)
			lines_sent++;
	endtask

	task automatic send_line(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == s.len() - 1);
	endtask

	// hold the input until every predicted token has come out
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tokens_pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned len;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		char_byte   = 8'h00;
		end_of_line = 1'b0;
		calm        = 0;
		bytes_sent  = 0;
		lines_sent  = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-byte line of all ones, every operator back to back,
		// lone ampersand with an open quote, NUL word and trailing blanks,
		// single quote inside double quotes
		send_byte(8'hFF, 1);
		send_line("(||&&>><<|<>)");
		send_line("a&b'");
		send_byte(8'h00, 0);
		send_byte(CH_TAB, 0);
		send_byte(CH_NL, 1);
		send_line("\"'\"");

		while (bytes_sent < RANDOM_BYTES) begin
			calm = (bytes_sent > 150 && bytes_sent < 260);
			if (lines_sent == 25)
				hold_until_drained();
			len = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
			for (int i = 0; i < len; i++)
				send_byte(shell_char(), i == len - 1);
		end
		calm = 0;

		hold_until_drained();
		repeat (20) @(posedge clk);

		$display("Sent %0d bytes in %0d lines of directed and random text.",
			bytes_sent, lines_sent);
		$display("Compared %0d tokens under random stalls on both channels.", tokens_checked);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
